// ===== rtl/core/spectrum_bar_log_smoother_top_defines.svh =====
// Assertion macros shared by the smoother RTL.
// Simulation builds get the checks; synthesis builds define SYNTH and get nothing.
`ifndef SPECTRUM_BAR_LOG_SMOOTHER_TOP_DEFINES_SVH
`define SPECTRUM_BAR_LOG_SMOOTHER_TOP_DEFINES_SVH

`ifndef SYNTH

// A property that must hold on every clock edge outside reset.
`define SBLS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// A condition that must never be seen outside reset.
`define SBLS_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define SBLS_ASSERT(lbl, clk, rst, prop, msg)
`define SBLS_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== rtl/core/sbls_pkg.sv =====
package sbls_pkg;

   // Defaults of the top-level parameters.
   localparam int MAX_BANDS_DEF  = 32;
   localparam int BIN_STRIDE_DEF = 12;
   localparam int MAG_BITS_DEF   = 24;

   // Field and register widths.
   localparam int BAND_W   = 5;
   localparam int MAG_W    = 24;
   localparam int SCALE_W  = 16;
   localparam int OFF_W    = 24;
   localparam int COUNT_W  = 6;
   localparam int HEIGHT_W = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Log unit: 64-bit operand, 32-bit mantissa, result is exponent.fraction in Q.16.
   localparam int LOG_IN_W = 64;
   localparam int MANT_W   = 32;
   localparam int EXP_W    = $clog2(LOG_IN_W);
   localparam int FRAC_W   = 16;
   localparam int LOG_W    = EXP_W + FRAC_W;
   localparam int NORM_STEPS = $clog2(LOG_IN_W);

   // Smoothing datapath widths.
   localparam int LN_W  = 16;
   localparam int H_W   = 12;
   localparam int MIX_W = 17;

   localparam int QUEUE_DEPTH = 2;

   // ln(2) in Q16, and the reciprocal of three scaled by 2^17 (rounded up).
   localparam logic [15:0]         LN2_Q16    = 16'd45426;
   localparam logic [MIX_W-1:0]    RECIP3     = 17'd43691;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 15'h7FFF;

   // Register reset values.
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd48998;
   localparam logic [OFF_W-1:0]   OFFSET_RESET = 24'd10495;
   localparam logic [COUNT_W-1:0] COUNT_RESET  = 6'd20;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BAR_SCALE  = 2'd0,
      CSR_LOG_OFFSET = 2'd1,
      CSR_BAND_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic [OFF_W-1:0]   offset;
      logic [COUNT_W-1:0] count;
   } sbls_cfg_type;

   // One classified band waiting for the back end.
   typedef struct packed {
      logic [BAND_W-1:0]   band;
      logic [BAND_W-1:0]   idx;
      logic                last;
      logic                own_left;
      logic                own_right;
      logic [LOG_IN_W-1:0] sum;
      logic [OFF_W-1:0]    off;
   } sbls_item_type;

endpackage

// ===== rtl/core/sbls_log2.sv =====
module sbls_log2 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sbls_pkg::LOG_IN_W-1:0] value,
   output logic                          res_valid,
   output logic [sbls_pkg::LOG_W-1:0]    result
);
   import sbls_pkg::*;

   localparam int STEP_W = $clog2(FRAC_W);

   typedef enum logic [2:0] {
      L_IDLE = 3'b001,
      L_NORM = 3'b010,
      L_SQR  = 3'b100
   } log_state_type;

   log_state_type       state_ff, state_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic                valid_ff, valid_in;
   logic [LOG_IN_W-1:0] v_ff, v_in;
   logic [EXP_W-1:0]    e_ff, e_in;
   logic [MANT_W-1:0]   m_ff, m_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;

   logic [EXP_W-1:0]      sh;
   logic [LOG_IN_W-1:0]   top_mask;
   logic [2*MANT_W-1:0]   sq;
   logic [MANT_W:0]       sq_top;

   // Binary search for the leading one, then one squaring step per cycle.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      v_in     = v_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;

      sh       = EXP_W'(LOG_IN_W / 2) >> cnt_ff;
      top_mask = ~({LOG_IN_W{1'b1}} >> sh);
      sq       = {{MANT_W{1'b0}}, m_ff} * {{MANT_W{1'b0}}, m_ff};
      sq_top   = sq[2*MANT_W-1:MANT_W-1];

      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               state_in = L_NORM;
               cnt_in   = '0;
               valid_in = 1'b0;
               v_in     = value;
               e_in     = EXP_W'(LOG_IN_W - 1);
               frac_in  = '0;
            end
         end
         L_NORM: begin
            if ((v_ff & top_mask) == '0) begin
               v_in = v_ff << sh;
               e_in = e_ff - sh;
            end
            m_in = v_in[LOG_IN_W-1 -: MANT_W];
            if (cnt_ff == STEP_W'(NORM_STEPS - 1)) begin
               state_in = L_SQR;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         L_SQR: begin
            if (sq_top[MANT_W]) begin
               m_in    = sq_top[MANT_W:1];
               frac_in = {frac_ff[FRAC_W-2:0], 1'b1};
            end else begin
               m_in    = sq_top[MANT_W-1:0];
               frac_in = {frac_ff[FRAC_W-2:0], 1'b0};
            end
            if (cnt_ff == STEP_W'(FRAC_W - 1)) begin
               state_in = L_IDLE;
               valid_in = 1'b1;
            end
            cnt_in = cnt_ff + STEP_W'(1);
         end
         default: state_in = L_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // Operand and result registers.
   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
   end

   assign res_valid = valid_ff;
   assign result    = {e_ff, frac_ff};

endmodule

// ===== rtl/core/sbls_fifo.sv =====
module sbls_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sbls_pkg::sbls_item_type push_data,
   output logic                    full,
   input  logic                    pop,
   output sbls_pkg::sbls_item_type pop_data,
   output logic                    empty
);
   import sbls_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   sbls_item_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue slots.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);

endmodule

// ===== rtl/core/sbls_front.sv =====
module sbls_front #(
   parameter int MAX_BANDS  = sbls_pkg::MAX_BANDS_DEF,
   parameter int BIN_STRIDE = sbls_pkg::BIN_STRIDE_DEF,
   parameter int MAG_BITS   = sbls_pkg::MAG_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sbls_pkg::sbls_cfg_type      cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [sbls_pkg::BAND_W-1:0] req_band,
   input  logic [sbls_pkg::MAG_W-1:0]  req_magnitude,
   output logic                        push,
   output sbls_pkg::sbls_item_type     push_data,
   input  logic                        full
);
   import sbls_pkg::*;

   localparam int MAG_USE_W = (MAG_BITS < MAG_W) ? MAG_BITS : MAG_W;
   localparam int WT_W      = $clog2((MAX_BANDS - 1) * BIN_STRIDE + 2);
   localparam int PROD_W    = MAG_USE_W + WT_W;
   localparam int SUM_W     = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 1;
   localparam int LAST_IDX  = MAX_BANDS - 1;

   logic                  stg_valid_ff, stg_valid_in;
   logic [BAND_W-1:0]     stg_band_ff;
   logic [BAND_W-1:0]     stg_idx_ff;
   logic                  stg_last_ff;
   logic [MAG_USE_W-1:0]  stg_mag_ff;
   logic [OFF_W-1:0]      stg_off_ff;

   logic                  accept;
   logic [BAND_W-1:0]     idx_in;
   logic                  last_in;
   logic [OFF_W-1:0]      off_in;
   logic [WT_W-1:0]       wt;
   logic [PROD_W-1:0]     prod;
   logic [SUM_W-1:0]      sum;

   assign push      = stg_valid_ff && !full;
   assign req_ready = !stg_valid_ff || !full;
   assign accept    = req_valid && req_ready;

   // Classify the request: table entry, frame end, effective offset.
   always_comb begin
      idx_in  = (int'(req_band) < MAX_BANDS) ? req_band : BAND_W'(LAST_IDX);
      last_in = (({1'b0, req_band} + COUNT_W'(1)) == cfg.count);
      off_in  = (cfg.offset == '0) ? OFF_W'(1) : cfg.offset;
      stg_valid_in = stg_valid_ff;
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (push) begin
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_band_ff <= req_band;
         stg_idx_ff  <= idx_in;
         stg_last_ff <= last_in;
         stg_mag_ff  <= req_magnitude[MAG_USE_W-1:0];
         stg_off_ff  <= off_in;
      end
   end

   // Weight the magnitude by its band and add the offset for the log.
   always_comb begin
      wt   = WT_W'(int'(stg_idx_ff) * BIN_STRIDE + 1);
      prod = {{WT_W{1'b0}}, stg_mag_ff} * {{MAG_USE_W{1'b0}}, wt};
      sum  = SUM_W'(prod) + SUM_W'(stg_off_ff);

      push_data.band      = stg_band_ff;
      push_data.idx       = stg_idx_ff;
      push_data.last      = stg_last_ff;
      push_data.own_left  = (stg_idx_ff == '0);
      push_data.own_right = stg_last_ff || ((int'(stg_idx_ff) + 1) >= MAX_BANDS);
      push_data.sum       = LOG_IN_W'(sum);
      push_data.off       = stg_off_ff;
   end

endmodule

// ===== rtl/core/sbls_back.sv =====
`include "spectrum_bar_log_smoother_top_defines.svh"

module sbls_back #(
   parameter int MAX_BANDS = sbls_pkg::MAX_BANDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sbls_pkg::sbls_cfg_type        cfg,
   input  logic                          empty,
   output logic                          pop,
   input  sbls_pkg::sbls_item_type       pop_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sbls_pkg::BAND_W-1:0]   rsp_band_out,
   output logic [sbls_pkg::HEIGHT_W-1:0] rsp_bar_height,
   output logic                          rsp_frame_last
);
   import sbls_pkg::*;

   localparam int IDX_W  = $clog2(MAX_BANDS);
   localparam int LNP_W  = LOG_W + 16;
   localparam int HP_W   = SCALE_W + LN_W;
   localparam int QP_W   = 2 * MIX_W;

   typedef enum logic [9:0] {
      B_IDLE     = 10'b0000000001,
      B_RD_LEFT  = 10'b0000000010,
      B_RD_OLD   = 10'b0000000100,
      B_RD_RIGHT = 10'b0000001000,
      B_RD_DONE  = 10'b0000010000,
      B_LOG      = 10'b0000100000,
      B_LN       = 10'b0001000000,
      B_H        = 10'b0010000000,
      B_MIX      = 10'b0100000000,
      B_DIV      = 10'b1000000000
   } back_state_type;

   back_state_type        state_ff, state_in;
   sbls_item_type         cur_ff;
   logic [IDX_W-1:0]      cur_addr;
   logic [IDX_W-1:0]      rd_addr;

   logic [HEIGHT_W-1:0]   heights_mem [MAX_BANDS];
   logic [MAX_BANDS-1:0]  valid_ff;
   logic [HEIGHT_W-1:0]   rd_q_ff;
   logic                  rdv_ff;
   logic [HEIGHT_W-1:0]   rd_val;
   logic                  mem_we;

   logic [HEIGHT_W-1:0]   left_ff, old_ff, right_ff;
   logic [LOG_W-1:0]      diff_ff, diff_in;
   logic [LN_W-1:0]       ln_ff, ln_in;
   logic [H_W-1:0]        h_ff, h_in;
   logic [MIX_W-1:0]      x_ff, x_in;
   logic [HEIGHT_W-1:0]   nv;

   logic                  la_valid, lb_valid;
   logic [LOG_W-1:0]      la, lb;
   logic [LNP_W-1:0]      ln_prod;
   logic [HP_W-1:0]       h_prod;
   logic [QP_W-1:0]       q_prod;
   logic [MIX_W-1:0]      q;
   logic [HEIGHT_W-1:0]   nb_left, nb_right;
   logic [MIX_W-1:0]      spread;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BAND_W-1:0]     rsp_band_ff;
   logic [HEIGHT_W-1:0]   rsp_height_ff;
   logic                  rsp_last_ff;
   logic                  out_free;
   logic                  out_load;

   assign cur_addr = IDX_W'(cur_ff.idx);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Log of weighted magnitude plus offset, and log of the offset, side by side.
   sbls_log2 u_log_a (
      .clock     (clock),
      .reset     (reset),
      .start     (pop),
      .value     (pop_data.sum),
      .res_valid (la_valid),
      .result    (la)
   );

   sbls_log2 u_log_b (
      .clock     (clock),
      .reset     (reset),
      .start     (pop),
      .value     (LOG_IN_W'(pop_data.off)),
      .res_valid (lb_valid),
      .result    (lb)
   );

   // Sequencer: three table reads while the logs run, then the smoothing steps.
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      mem_we   = 1'b0;
      out_load = 1'b0;
      rd_addr  = cur_addr;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               state_in = B_RD_LEFT;
            end
         end
         B_RD_LEFT: begin
            rd_addr  = cur_addr - IDX_W'(1);
            state_in = B_RD_OLD;
         end
         B_RD_OLD:   state_in = B_RD_RIGHT;
         B_RD_RIGHT: begin
            rd_addr  = cur_addr + IDX_W'(1);
            state_in = B_RD_DONE;
         end
         B_RD_DONE:  state_in = B_LOG;
         B_LOG: begin
            if (la_valid && lb_valid) begin
               state_in = B_LN;
            end
         end
         B_LN:  state_in = B_H;
         B_H:   state_in = B_MIX;
         B_MIX: state_in = B_DIV;
         B_DIV: begin
            if (out_free) begin
               mem_we   = 1'b1;
               out_load = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Arithmetic of each step; every product lands in a register.
   always_comb begin
      diff_in = (la > lb) ? (la - lb) : '0;

      ln_prod = {16'b0, diff_ff} * {{LOG_W{1'b0}}, LN2_Q16};
      ln_in   = (ln_prod[LNP_W-1:20] > (LNP_W - 20)'({LN_W{1'b1}})) ?
                {LN_W{1'b1}} : ln_prod[20 +: LN_W];

      h_prod  = {{LN_W{1'b0}}, cfg.scale} * {{SCALE_W{1'b0}}, ln_ff};
      h_in    = h_prod[HP_W-1 -: H_W];

      nb_left  = cur_ff.own_left  ? HEIGHT_W'(h_ff) : left_ff;
      nb_right = cur_ff.own_right ? HEIGHT_W'(h_ff) : right_ff;
      spread   = MIX_W'({h_ff, 1'b0}) + MIX_W'(nb_left) + MIX_W'(nb_right);
      x_in     = MIX_W'({old_ff, 1'b0}) + MIX_W'(spread[MIX_W-1:2]);

      q_prod = {{MIX_W{1'b0}}, x_ff} * {{MIX_W{1'b0}}, RECIP3};
      q      = q_prod[QP_W-1 -: MIX_W];
      nv     = (q > MIX_W'(HEIGHT_MAX)) ? HEIGHT_MAX : q[HEIGHT_W-1:0];
   end

   // Entries never written since reset read as zero.
   assign rd_val = rdv_ff ? rd_q_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (mem_we) begin
            valid_ff[cur_addr] <= 1'b1;
         end
      end
   end

   // Height table with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heights_mem[cur_addr] <= nv;
      end
      rd_q_ff <= heights_mem[rd_addr];
      rdv_ff  <= valid_ff[rd_addr];
   end

   // Working registers of the current band.
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_data;
      end
      if (state_ff == B_RD_OLD) begin
         left_ff <= rd_val;
      end
      if (state_ff == B_RD_RIGHT) begin
         old_ff <= rd_val;
      end
      if (state_ff == B_RD_DONE) begin
         right_ff <= rd_val;
      end
      if (state_ff == B_LOG) begin
         diff_ff <= diff_in;
      end
      if (state_ff == B_LN) begin
         ln_ff <= ln_in;
      end
      if (state_ff == B_H) begin
         h_ff <= h_in;
      end
      if (state_ff == B_MIX) begin
         x_ff <= x_in;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_band_ff   <= cur_ff.band;
         rsp_height_ff <= nv;
         rsp_last_ff   <= cur_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_band_out   = rsp_band_ff;
   assign rsp_bar_height = rsp_height_ff;
   assign rsp_frame_last = rsp_last_ff;

   // Both log units run the same fixed step count and must finish together.
   `SBLS_NEVER(a_logs_in_step, clock, reset, la_valid != lb_valid, "log units out of step")
   // The band under work does not change until its result is out.
   `SBLS_ASSERT(a_item_held, clock, reset, (state_ff != B_IDLE) |=> $stable(cur_ff), "band changed while busy")
   // A blocked result keeps the sequencer in its final step.
   `SBLS_ASSERT(a_out_wait, clock, reset, (state_ff == B_DIV && !out_free) |=> (state_ff == B_DIV && rsp_valid_ff), "result lost under stall")
   // A written entry reads back as written from then on.
   `SBLS_ASSERT(a_entry_valid, clock, reset, mem_we |=> valid_ff[$past(cur_addr)], "height entry not marked written")

endmodule

// ===== rtl/core/spectrum_bar_log_smoother_top.sv =====
// Spectrum bar smoother: one band magnitude in, one smoothed bar height out.
// Requests arrive on req_valid/req_ready with req_band and req_magnitude, bands in
// ascending order within a frame. Each request gives exactly one response on
// rsp_valid/rsp_ready with the band, its new height and a frame-end flag.
// Registers bar_scale, log_offset and band_count are written through csr_valid,
// csr_index and csr_data; csr_ready is always high. Write them only while idle.
// The back end handles one request at a time and pops the next only after the
// result of the last is loaded into the response register. Its work is set
// by the two log2 units, each taking 6 normalization steps and 16 squaring steps
// on one 32x32 multiplier per cycle, followed by four multiply and mix steps.
// A front stage and a two-entry queue hold up to three further requests while the
// back end works; req_ready drops only once the stage and queue are both full.
// Reset loads the register defaults (48998, 10495, 20) and marks every stored
// height as unwritten, so all heights read as zero; no clearing pass is needed.
// When the receiver stalls, the response register holds its value, the back end
// waits in its final step, the queue fills and req_ready then drops.
module spectrum_bar_log_smoother_top #(
   parameter int MAX_BANDS  = sbls_pkg::MAX_BANDS_DEF,
   parameter int BIN_STRIDE = sbls_pkg::BIN_STRIDE_DEF,
   parameter int MAG_BITS   = sbls_pkg::MAG_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sbls_pkg::BAND_W-1:0]     req_band,
   input  logic [sbls_pkg::MAG_W-1:0]      req_magnitude,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sbls_pkg::BAND_W-1:0]     rsp_band_out,
   output logic [sbls_pkg::HEIGHT_W-1:0]   rsp_bar_height,
   output logic                            rsp_frame_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sbls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbls_pkg::CSR_DATA_W-1:0] csr_data
);
   import sbls_pkg::*;

   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [OFF_W-1:0]   offset_ff, offset_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   sbls_cfg_type       cfg;

   logic               push, pop, full, empty;
   sbls_item_type      push_data, pop_data;

   assign csr_ready = 1'b1;

   // Configuration registers; writes to unknown indexes are dropped.
   always_comb begin
      scale_in  = scale_ff;
      offset_in = offset_ff;
      count_in  = count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BAR_SCALE:  scale_in  = csr_data[SCALE_W-1:0];
            CSR_LOG_OFFSET: offset_in = csr_data[OFF_W-1:0];
            CSR_BAND_COUNT: count_in  = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         offset_ff <= OFFSET_RESET;
         count_ff  <= COUNT_RESET;
      end else begin
         scale_ff  <= scale_in;
         offset_ff <= offset_in;
         count_ff  <= count_in;
      end
   end

   assign cfg.scale  = scale_ff;
   assign cfg.offset = offset_ff;
   assign cfg.count  = count_ff;

   sbls_front #(
      .MAX_BANDS  (MAX_BANDS),
      .BIN_STRIDE (BIN_STRIDE),
      .MAG_BITS   (MAG_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_band      (req_band),
      .req_magnitude (req_magnitude),
      .push          (push),
      .push_data     (push_data),
      .full          (full)
   );

   sbls_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   sbls_back #(
      .MAX_BANDS (MAX_BANDS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .empty          (empty),
      .pop            (pop),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_band_out   (rsp_band_out),
      .rsp_bar_height (rsp_bar_height),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
